// File: rtl/core/ltc_pkg.sv
// Shared types, codes and keyword/operator tables for the token classifier.
package ltc_pkg;

   localparam int unsigned WordCount    = 27;
   localparam int unsigned KeywordCount = 16;
   localparam int unsigned WordMaxLen   = 8;
   localparam int unsigned RspDepth     = 8;

   localparam logic [7:0] CharSemicolon  = 8'd59;
   localparam logic [7:0] CharDot        = 8'd46;
   localparam logic [7:0] CharUnderscore = 8'd95;
   localparam logic [7:0] CharSpace      = 8'd32;
   localparam logic [7:0] CharTab        = 8'd9;
   localparam logic [7:0] CharCr         = 8'd13;
   localparam logic [7:0] CharZero       = 8'd48;
   localparam logic [7:0] CharNine       = 8'd57;
   localparam logic [7:0] CharLowA       = 8'd97;
   localparam logic [7:0] CharLowZ       = 8'd122;

   localparam logic [3:0] PosMax = 4'd15;

   typedef enum logic [2:0] {
      ClsReserved = 3'd0,
      ClsInteger  = 3'd1,
      ClsFloat    = 3'd2,
      ClsOperator = 3'd3,
      ClsVariable = 3'd4,
      ClsError    = 3'd5,
      ClsStmtEnd  = 3'd6,
      ClsTextEnd  = 3'd7
   } token_class_type;

   typedef enum logic [1:0] {
      FckOther = 2'd0,
      FckDigit = 2'd1,
      FckName  = 2'd2
   } first_kind_type;

   typedef struct packed {
      logic [2:0] token_class;
      logic       error_seen;
      logic       last_result;
   } rsp_entry_type;

   // up to three results per input beat, in emit order: token, stmt end, text end
   typedef struct packed {
      logic [2:0]          valid;
      rsp_entry_type [2:0] entry;
   } push_type;

   localparam logic [7:0] WordChar [WordCount][WordMaxLen] = '{
      '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00},
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
      '{"d", "o", "u", "b", "l", "e", 8'h00, 8'h00},
      '{"l", "o", "n", "g", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"s", "t", "a", "t", "i", "c", 8'h00, 8'h00},
      '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "x", "t", "e", "r", "n", 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
      '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
      '{"e", "n", "u", "m", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"s", "t", "r", "u", "c", "t", 8'h00, 8'h00},
      '{"t", "y", "p", "e", "d", "e", "f", 8'h00},
      '{"u", "n", "i", "o", "n", 8'h00, 8'h00, 8'h00},
      '{"g", "o", "t", "o", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"+", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"-", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"*", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"/", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"=", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"!", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{">", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"<", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"<", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [3:0] WordLen [WordCount] = '{
      4'd5, 4'd3, 4'd5, 4'd6, 4'd4, 4'd6, 4'd4, 4'd4,
      4'd6, 4'd6, 4'd5, 4'd4, 4'd6, 4'd7, 4'd5, 4'd4,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd1, 4'd1
   };

endpackage

// File: rtl/core/ltc_scan.sv
// Per-byte tokenizer: token state registers, keyword match mask and classification.
module ltc_scan
   import ltc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] char_code,
   input  logic       end_of_text,
   output push_type   push
);

   logic                 in_token_ff, in_token_in;
   logic [3:0]           pos_ff, pos_in;
   logic [WordCount-1:0] mask_ff, mask_in;
   first_kind_type       fck_ff, fck_in;
   logic [1:0]           score_ff, score_in;
   logic                 name_ok_ff, name_ok_in;
   logic                 sticky_ff, sticky_in;

   // state after feeding this byte
   logic [3:0]           fed_pos;
   logic [WordCount-1:0] fed_mask;
   first_kind_type       fed_fck;
   logic [1:0]           fed_score;
   logic                 fed_name_ok;

   // state the closing token is classed from
   logic [3:0]           cls_pos;
   logic [WordCount-1:0] cls_mask;
   first_kind_type       cls_fck;
   logic [1:0]           cls_score;
   logic                 cls_name_ok;

   logic                 is_sep, is_semi, is_lower, is_digit, is_under;
   logic [3:0]           eff_pos;
   logic [WordCount-1:0] eff_mask, hit;
   logic [2:0]           score_sum;
   logic                 tok_valid, sticky_after;
   token_class_type      tok_class;

   assign is_semi  = (char_code == CharSemicolon);
   assign is_sep   = (char_code == CharSpace) || is_semi ||
                     ((char_code >= CharTab) && (char_code <= CharCr));
   assign is_lower = (char_code >= CharLowA) && (char_code <= CharLowZ);
   assign is_digit = (char_code >= CharZero) && (char_code <= CharNine);
   assign is_under = (char_code == CharUnderscore);

   assign eff_pos  = in_token_ff ? pos_ff : 4'd0;
   assign eff_mask = in_token_ff ? mask_ff : '1;

   always_comb begin
      for (int k = 0; k < WordCount; k++) begin
         fed_mask[k] = eff_mask[k] && (eff_pos < WordLen[k]) &&
                       (WordChar[k][eff_pos[2:0]] == char_code);
      end
   end

   always_comb begin
      fed_fck = fck_ff;
      if (!in_token_ff) begin
         if (is_digit) begin
            fed_fck = FckDigit;
         end else if (is_lower || is_under) begin
            fed_fck = FckName;
         end else begin
            fed_fck = FckOther;
         end
      end
   end

   assign score_sum = {1'b0, (in_token_ff ? score_ff : 2'd0)} +
                      {2'b00, (char_code == CharDot)} + {is_lower, 2'b00} / 3'd2;
   assign fed_score   = (score_sum > 3'd2) ? 2'd2 : score_sum[1:0];
   assign fed_name_ok = (in_token_ff ? name_ok_ff : 1'b1) &&
                        (is_lower || is_digit || is_under);
   assign fed_pos     = (eff_pos < PosMax) ? eff_pos + 4'd1 : PosMax;

   assign cls_pos     = is_sep ? pos_ff     : fed_pos;
   assign cls_mask    = is_sep ? mask_ff    : fed_mask;
   assign cls_fck     = is_sep ? fck_ff     : fed_fck;
   assign cls_score   = is_sep ? score_ff   : fed_score;
   assign cls_name_ok = is_sep ? name_ok_ff : fed_name_ok;

   always_comb begin
      for (int k = 0; k < WordCount; k++) begin
         hit[k] = cls_mask[k] && (WordLen[k] == cls_pos);
      end
   end

   always_comb begin
      if (|hit[KeywordCount-1:0]) begin
         tok_class = ClsReserved;
      end else if (|hit[WordCount-1:KeywordCount]) begin
         tok_class = ClsOperator;
      end else if (cls_fck == FckDigit) begin
         case (cls_score)
            2'd0:    tok_class = ClsInteger;
            2'd1:    tok_class = ClsFloat;
            default: tok_class = ClsError;
         endcase
      end else if ((cls_fck == FckName) && cls_name_ok) begin
         tok_class = ClsVariable;
      end else begin
         tok_class = ClsError;
      end
   end

   // a non-separator byte always leaves a token open, so end of text closes it
   assign tok_valid    = is_sep ? in_token_ff : end_of_text;
   assign sticky_after = sticky_ff || (tok_valid && (tok_class == ClsError));

   always_comb begin
      push.valid[0]             = accept && tok_valid;
      push.entry[0].token_class = tok_class;
      push.entry[0].error_seen  = sticky_after;
      push.entry[0].last_result = 1'b0;
      push.valid[1]             = accept && is_semi;
      push.entry[1].token_class = ClsStmtEnd;
      push.entry[1].error_seen  = sticky_after;
      push.entry[1].last_result = 1'b0;
      push.valid[2]             = accept && end_of_text;
      push.entry[2].token_class = ClsTextEnd;
      push.entry[2].error_seen  = sticky_after;
      push.entry[2].last_result = 1'b1;
   end

   always_comb begin
      in_token_in = in_token_ff;
      pos_in      = pos_ff;
      mask_in     = mask_ff;
      fck_in      = fck_ff;
      score_in    = score_ff;
      name_ok_in  = name_ok_ff;
      sticky_in   = sticky_ff;
      if (accept) begin
         sticky_in = sticky_after;
         if (end_of_text) begin
            in_token_in = 1'b0;
            pos_in      = 4'd0;
            mask_in     = '1;
            fck_in      = FckOther;
            score_in    = 2'd0;
            name_ok_in  = 1'b1;
            sticky_in   = 1'b0;
         end else if (is_sep) begin
            in_token_in = 1'b0;
         end else begin
            in_token_in = 1'b1;
            pos_in      = fed_pos;
            mask_in     = fed_mask;
            fck_in      = fed_fck;
            score_in    = fed_score;
            name_ok_in  = fed_name_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff <= 1'b0;
         pos_ff      <= 4'd0;
         mask_ff     <= '1;
         fck_ff      <= FckOther;
         score_ff    <= 2'd0;
         name_ok_ff  <= 1'b1;
         sticky_ff   <= 1'b0;
      end else begin
         in_token_ff <= in_token_in;
         pos_ff      <= pos_in;
         mask_ff     <= mask_in;
         fck_ff      <= fck_in;
         score_ff    <= score_in;
         name_ok_ff  <= name_ok_in;
         sticky_ff   <= sticky_in;
      end
   end

endmodule

// File: rtl/core/ltc_rsp_fifo.sv
// Result queue: takes up to three results per beat, drains one per beat.
module ltc_rsp_fifo
   import ltc_pkg::*;
#(
   parameter int unsigned DEPTH = RspDepth
)
(
   input  logic          clock,
   input  logic          reset,
   input  push_type      push,
   output logic          room,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_entry_type rsp_entry
);

   localparam int unsigned AddrW = $clog2(DEPTH);
   localparam int unsigned CntW  = $clog2(DEPTH + 1);

   rsp_entry_type    mem_ff [DEPTH];
   rsp_entry_type    out_ff;
   logic             out_valid_ff, out_valid_in;
   logic [AddrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [1:0]       off1, off2, push_n;
   logic             pop, load;

   assign off1   = {1'b0, push.valid[0]};
   assign off2   = off1 + {1'b0, push.valid[1]};
   assign push_n = off2 + {1'b0, push.valid[2]};
   assign pop    = rsp_valid && rsp_ready;

   // output register refills when the queue is non-empty and the register is empty or drained this cycle
   assign load = (count_ff != '0) && (!out_valid_ff || pop);

   // three free slots are needed before a beat can come in
   assign room      = (count_ff <= CntW'(DEPTH - 3));
   assign rsp_valid = out_valid_ff;
   assign rsp_entry = out_ff;

   assign wr_ptr_in    = wr_ptr_ff + AddrW'(push_n);
   assign rd_ptr_in    = rd_ptr_ff + AddrW'(load);
   assign count_in     = count_ff + CntW'(push_n) - CntW'(load);
   assign out_valid_in = load || (out_valid_ff && !pop);

   always_ff @(posedge clock) begin
      if (push.valid[0]) begin
         mem_ff[wr_ptr_ff] <= push.entry[0];
      end
      if (push.valid[1]) begin
         mem_ff[wr_ptr_ff + AddrW'(off1)] <= push.entry[1];
      end
      if (push.valid[2]) begin
         mem_ff[wr_ptr_ff + AddrW'(off2)] <= push.entry[2];
      end
      if (load) begin
         out_ff <= mem_ff[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// File: rtl/core/lexical_token_classifier_unit.sv
// Top level of the lexical token classifier: byte scanner plus result queue.
//
// Usage: source text enters one byte per beat on the req_ channel
// (req_char_code, req_end_of_text marks the last byte). Whitespace and ';'
// close the open token; each closed token yields one rsp_ beat with its
// class, ';' adds a statement-end beat, and end of text adds a final beat
// with rsp_last_result set, after which the scanner starts a fresh text.
// Results of a byte pass through the queue memory and then the output register
// before they appear on rsp_. Throughput: one byte per cycle. A byte yields
// zero to three results and the rsp_ side drains one per cycle while
// rsp_ready is high; req_ready stays high as long as the RSP_DEPTH-entry
// result queue (power of two, at least 4) has three free slots, so a stalled
// receiver holds back input only once fewer than three slots are free.
// Reset (synchronous, active high) empties the queue and clears the token
// state and the sticky error flag.
module lexical_token_classifier_unit
   import ltc_pkg::*;
#(
   parameter int unsigned RSP_DEPTH = RspDepth
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_token_class,
   output logic       rsp_error_seen,
   output logic       rsp_last_result
);

   push_type      push;
   rsp_entry_type rsp_entry;
   logic          room;
   logic          accept;

   assign req_ready = room;
   assign accept    = req_valid && room;

   ltc_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_code   (req_char_code),
      .end_of_text (req_end_of_text),
      .push        (push)
   );

   ltc_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_entry (rsp_entry)
   );

   assign rsp_token_class = rsp_entry.token_class;
   assign rsp_error_seen  = rsp_entry.error_seen;
   assign rsp_last_result = rsp_entry.last_result;

endmodule

// File: rtl/core/ltc_checker.sv
// Port-level checks for the token classifier, bound to the top level.
module ltc_checker
   import ltc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_end_of_text,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_token_class,
   input logic       rsp_error_seen,
   input logic       rsp_last_result
);

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // an end-of-text beat always leaves at least its text-end result
   a_eot_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end_of_text) |=> ##1 rsp_valid)
      else $error("no result after end of text");

   a_last_is_text_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_result == (rsp_token_class == ClsTextEnd)))
      else $error("last_result does not match text-end class");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_token_class == ClsError)) |-> rsp_error_seen)
      else $error("error token without error flag");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_token_class) &&
                                     $stable(rsp_error_seen) && $stable(rsp_last_result)))
      else $error("stalled result beat changed");

endmodule

bind lexical_token_classifier_unit ltc_checker u_ltc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_end_of_text (req_end_of_text),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_token_class (rsp_token_class),
   .rsp_error_seen  (rsp_error_seen),
   .rsp_last_result (rsp_last_result)
);
